// ===== src/dssup_pkg.sv =====
// Shared types, constants and helpers for the drip-stop alarm supervisor.
package dssup_pkg;

	localparam int COUNT_BITS    = 16;
	localparam int RATE_BITS     = 12;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = (COUNT_BITS > RATE_BITS) ? COUNT_BITS : RATE_BITS;

	localparam logic [CFG_IDX_BITS-1:0] REG_RATE_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_WARMUP_TICKS   = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_TICKS     = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_RECOVERY_TICKS = 2'd3;

	localparam logic [RATE_BITS-1:0]  RST_RATE_THRESHOLD = RATE_BITS'(10);
	localparam logic [COUNT_BITS-1:0] RST_WARMUP_TICKS   = COUNT_BITS'(300);
	localparam logic [COUNT_BITS-1:0] RST_HOLD_TICKS     = COUNT_BITS'(30);
	localparam logic [COUNT_BITS-1:0] RST_RECOVERY_TICKS = COUNT_BITS'(10);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_ACTIVE = 2'd1;
	localparam logic [1:0] ST_HOLD   = 2'd2;

	localparam logic [2:0] TR_NONE      = 3'd0;
	localparam logic [2:0] TR_ACTIVE    = 3'd1;
	localparam logic [2:0] TR_RECOVERED = 3'd2;
	localparam logic [2:0] TR_HOLD      = 3'd3;
	localparam logic [2:0] TR_EXPIRED   = 3'd4;
	localparam logic [2:0] TR_RESTART   = 3'd5;

	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_HOLD = 1'b1;

	typedef struct packed {
		logic [RATE_BITS-1:0]  rate_threshold;
		logic [COUNT_BITS-1:0] warmup_ticks;
		logic [COUNT_BITS-1:0] hold_ticks;
		logic [COUNT_BITS-1:0] recovery_ticks;
	} cfg_t;

	typedef struct packed {
		logic                  mode;
		logic [RATE_BITS-1:0]  drop_rate;
		logic [COUNT_BITS-1:0] drop_count;
	} item_t;

	typedef struct packed {
		logic [1:0]           alarm_state;
		logic                 alarm_or_hold;
		logic [2:0]           transition;
		logic [RATE_BITS-1:0] display_rate;
	} res_t;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		sat_inc = (v == {COUNT_BITS{1'b1}}) ? v : v + COUNT_BITS'(1);
	endfunction

endpackage

// ===== src/dssup_cfg_regs.sv =====
// Configuration register file for the drip-stop alarm supervisor.
module dssup_cfg_regs (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr_en,
	input  logic [dssup_pkg::CFG_IDX_BITS-1:0]   wr_index,
	input  logic [dssup_pkg::CFG_DATA_BITS-1:0]  wr_data,
	output dssup_pkg::cfg_t                       cfg
);

	dssup_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate_threshold <= dssup_pkg::RST_RATE_THRESHOLD;
			cfg_q.warmup_ticks   <= dssup_pkg::RST_WARMUP_TICKS;
			cfg_q.hold_ticks     <= dssup_pkg::RST_HOLD_TICKS;
			cfg_q.recovery_ticks <= dssup_pkg::RST_RECOVERY_TICKS;
		end else if (wr_en) begin
			unique case (wr_index)
				dssup_pkg::REG_RATE_THRESHOLD:
					cfg_q.rate_threshold <= wr_data[dssup_pkg::RATE_BITS-1:0];
				dssup_pkg::REG_WARMUP_TICKS:
					cfg_q.warmup_ticks <= wr_data[dssup_pkg::COUNT_BITS-1:0];
				dssup_pkg::REG_HOLD_TICKS:
					cfg_q.hold_ticks <= wr_data[dssup_pkg::COUNT_BITS-1:0];
				dssup_pkg::REG_RECOVERY_TICKS:
					cfg_q.recovery_ticks <= wr_data[dssup_pkg::COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/dssup_fsm.sv =====
// Alarm state machine, saturating counters and per-item result logic.
module dssup_fsm (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  dssup_pkg::cfg_t     cfg,
	input  dssup_pkg::item_t    item,
	output dssup_pkg::res_t     res
);

	localparam int CB = dssup_pkg::COUNT_BITS;

	logic [1:0]    state_q, state_d;
	logic [CB-1:0] uptime_q, uptime_d;
	logic [CB-1:0] hold_q, hold_d;
	logic [CB-1:0] rec_q, rec_d;
	logic          run_q, run_d;
	logic [2:0]    tr;
	logic          good, due;

	always_comb begin
		state_d  = state_q;
		uptime_d = uptime_q;
		hold_d   = hold_q;
		rec_d    = rec_q;
		run_d    = run_q;
		tr       = dssup_pkg::TR_NONE;
		good     = item.drop_rate >= cfg.rate_threshold;
		due      = 1'b0;
		if (item.mode == dssup_pkg::MODE_HOLD) begin
			if (state_q == dssup_pkg::ST_HOLD) begin
				hold_d = '0;
				tr     = dssup_pkg::TR_RESTART;
			end else if (state_q == dssup_pkg::ST_IDLE) begin
				state_d = dssup_pkg::ST_HOLD;
				hold_d  = '0;
				tr      = dssup_pkg::TR_HOLD;
			end
		end else begin
			uptime_d = dssup_pkg::sat_inc(uptime_q);
			due = (item.drop_count != '0) && !good && (uptime_d >= cfg.warmup_ticks);
			unique case (state_q)
				dssup_pkg::ST_ACTIVE: begin
					if (!due && good) begin
						run_d = 1'b1;
						rec_d = run_q ? dssup_pkg::sat_inc(rec_q) : '0;
						if (rec_d >= cfg.recovery_ticks) begin
							state_d = dssup_pkg::ST_IDLE;
							run_d   = 1'b0;
							rec_d   = '0;
							tr      = dssup_pkg::TR_RECOVERED;
						end
					end else begin
						run_d = 1'b0;
						rec_d = '0;
					end
				end
				dssup_pkg::ST_HOLD: begin
					if (due) begin
						state_d = dssup_pkg::ST_ACTIVE;
						run_d   = 1'b0;
						rec_d   = '0;
						tr      = dssup_pkg::TR_ACTIVE;
					end else begin
						hold_d = dssup_pkg::sat_inc(hold_q);
						if (hold_d >= cfg.hold_ticks) begin
							state_d = dssup_pkg::ST_IDLE;
							hold_d  = '0;
							tr      = dssup_pkg::TR_EXPIRED;
						end
					end
				end
				default: begin
					if (due) begin
						state_d = dssup_pkg::ST_ACTIVE;
						run_d   = 1'b0;
						rec_d   = '0;
						tr      = dssup_pkg::TR_ACTIVE;
					end else begin
						state_d = dssup_pkg::ST_IDLE;
					end
				end
			endcase
		end
		res.alarm_state   = state_d;
		res.alarm_or_hold = (state_d == dssup_pkg::ST_ACTIVE) || (state_d == dssup_pkg::ST_HOLD);
		res.transition    = tr;
		res.display_rate  = good ? item.drop_rate : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= dssup_pkg::ST_IDLE;
			uptime_q <= '0;
			hold_q   <= '0;
			rec_q    <= '0;
			run_q    <= 1'b0;
		end else if (en) begin
			state_q  <= state_d;
			uptime_q <= uptime_d;
			hold_q   <= hold_d;
			rec_q    <= rec_d;
			run_q    <= run_d;
		end
	end

	a_run_only_active: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> (state_q == dssup_pkg::ST_ACTIVE))
		else $error("recovery running outside active state");

	a_rec_needs_run: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_q != '0) |-> run_q)
		else $error("recovery count set without recovery running");

	a_to_active: assert property (@(posedge clk) disable iff (!arst_n)
		(en && (res.transition == dssup_pkg::TR_ACTIVE)) |=> (state_q == dssup_pkg::ST_ACTIVE))
		else $error("alarm start did not reach active state");

	a_tick_uptime: assert property (@(posedge clk) disable iff (!arst_n)
		(en && (item.mode == dssup_pkg::MODE_TICK)) |=> (uptime_q != '0))
		else $error("uptime not advanced by tick");

endmodule

// ===== src/drip_stop_alarm_supervisor_core.sv =====
// Top level of the drip-stop alarm supervisor: input and result registers around the FSM.
//
// channel  dir  handshake            payload
// in       in   in_valid/in_ready    mode, drop_rate, drop_count
// out      out  out_valid/out_ready  alarm_state, alarm_or_hold, transition, display_rate
// cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per cycle while out_ready does not stall the output; each result passes through the input
// register and then the result register to the outputs. The state and counter update of the FSM sets the rate.
// Reset clears the state, counters and valid flags; configuration registers take their reset values.
// A stalled result holds in the output register; the input stage holds one more item.
// cfg_ready is always high.
module drip_stop_alarm_supervisor_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 mode,
	input  logic [dssup_pkg::RATE_BITS-1:0]      drop_rate,
	input  logic [dssup_pkg::COUNT_BITS-1:0]     drop_count,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [1:0]                           alarm_state,
	output logic                                 alarm_or_hold,
	output logic [2:0]                           transition,
	output logic [dssup_pkg::RATE_BITS-1:0]      display_rate,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [dssup_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [dssup_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	dssup_pkg::cfg_t  cfg;
	dssup_pkg::item_t item_s1;
	dssup_pkg::res_t  res;
	dssup_pkg::res_t  res_s2;
	logic             valid_s1;
	logic             valid_s2;
	logic             adv;

	assign cfg_ready = 1'b1;
	assign adv       = !valid_s2 || out_ready;
	assign in_ready  = !valid_s1 || adv;

	dssup_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	dssup_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (valid_s1 && adv),
		.cfg    (cfg),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.mode       <= mode;
			item_s1.drop_rate  <= drop_rate;
			item_s1.drop_count <= drop_count;
		end
		if (valid_s1 && adv) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign alarm_state   = res_s2.alarm_state;
	assign alarm_or_hold = res_s2.alarm_or_hold;
	assign transition    = res_s2.transition;
	assign display_rate  = res_s2.display_rate;

endmodule

// ===== bench/dssup_alarm_checker.sv =====
// Checker for the drip-stop alarm supervisor: tracks limits, predicts each status, compares.
module dssup_alarm_checker
	import dssup_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic                      mode,
	input  logic [RATE_BITS-1:0]      drop_rate,
	input  logic [COUNT_BITS-1:0]     drop_count,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [1:0]                alarm_state,
	input  logic                      alarm_or_hold,
	input  logic [2:0]                transition,
	input  logic [RATE_BITS-1:0]      display_rate,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	output int unsigned               fail_count,
	output int unsigned               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	cfg_t                  limits;
	logic [1:0]            fsm;
	logic [COUNT_BITS-1:0] uptime;
	logic [COUNT_BITS-1:0] hold_cnt;
	logic [COUNT_BITS-1:0] recov_cnt;
	logic                  recov_on;
	res_t                  pending_status [$];
	item_t                 taken;
	res_t                  fresh;
	res_t                  oldest;

	function automatic logic [COUNT_BITS-1:0] count_up(input logic [COUNT_BITS-1:0] v);
		return (&v) ? v : v + COUNT_BITS'(1);
	endfunction

	task automatic predict_status(input item_t it, output res_t r);
		logic       good;
		logic       due;
		logic [2:0] tr;
		good = it.drop_rate >= limits.rate_threshold;
		tr = TR_NONE;
		if (it.mode == MODE_HOLD) begin
			if (fsm == ST_HOLD) begin
				hold_cnt = '0;
				tr = TR_RESTART;
			end else if (fsm == ST_IDLE) begin
				fsm = ST_HOLD;
				hold_cnt = '0;
				tr = TR_HOLD;
			end
		end else begin
			uptime = count_up(uptime);
			due = (it.drop_count != '0) && !good && (uptime >= limits.warmup_ticks);
			if (fsm == ST_ACTIVE) begin
				if (!due && good) begin
					if (!recov_on) begin
						recov_on = 1'b1;
						recov_cnt = '0;
					end else begin
						recov_cnt = count_up(recov_cnt);
					end
					if (recov_cnt >= limits.recovery_ticks) begin
						fsm = ST_IDLE;
						recov_on = 1'b0;
						recov_cnt = '0;
						tr = TR_RECOVERED;
					end
				end else begin
					recov_on = 1'b0;
					recov_cnt = '0;
				end
			end else if (due) begin
				fsm = ST_ACTIVE;
				recov_on = 1'b0;
				recov_cnt = '0;
				tr = TR_ACTIVE;
			end else if (fsm == ST_HOLD) begin
				hold_cnt = count_up(hold_cnt);
				if (hold_cnt >= limits.hold_ticks) begin
					fsm = ST_IDLE;
					hold_cnt = '0;
					tr = TR_EXPIRED;
				end
			end
		end
		r.alarm_state = fsm;
		r.alarm_or_hold = (fsm == ST_ACTIVE) || (fsm == ST_HOLD);
		r.transition = tr;
		r.display_rate = good ? it.drop_rate : '0;
	endtask

	task automatic check_field(input string name, input int unsigned exp_v, input int unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits.rate_threshold = RST_RATE_THRESHOLD;
			limits.warmup_ticks = RST_WARMUP_TICKS;
			limits.hold_ticks = RST_HOLD_TICKS;
			limits.recovery_ticks = RST_RECOVERY_TICKS;
			fsm = ST_IDLE;
			uptime = '0;
			hold_cnt = '0;
			recov_cnt = '0;
			recov_on = 1'b0;
			pending_status.delete();
			pending = 0;
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_RATE_THRESHOLD: limits.rate_threshold = cfg_data[RATE_BITS-1:0];
					REG_WARMUP_TICKS:   limits.warmup_ticks = cfg_data[COUNT_BITS-1:0];
					REG_HOLD_TICKS:     limits.hold_ticks = cfg_data[COUNT_BITS-1:0];
					REG_RECOVERY_TICKS: limits.recovery_ticks = cfg_data[COUNT_BITS-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				taken.mode = mode;
				taken.drop_rate = drop_rate;
				taken.drop_count = drop_count;
				predict_status(taken, fresh);
				pending_status.push_back(fresh);
			end
			if (out_valid && out_ready) begin
				if (pending_status.size() == 0) begin
					$display("%0t: status transfer with none expected, got state %0d transition %0d rate %0d",
						$time, alarm_state, transition, display_rate);
					fail_count++;
				end else begin
					oldest = pending_status.pop_front();
					check_field("alarm_state", oldest.alarm_state, alarm_state);
					check_field("alarm_or_hold", oldest.alarm_or_hold, alarm_or_hold);
					check_field("transition", oldest.transition, transition);
					check_field("display_rate", oldest.display_rate, display_rate);
				end
			end
			pending = pending_status.size();
		end
	end

endmodule

// ===== bench/drip_stop_alarm_supervisor_core_tb.sv =====
// Stimulus and verdict for the drip-stop alarm supervisor core.
module drip_stop_alarm_supervisor_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dssup_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 800000;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      mode = MODE_TICK;
	logic [RATE_BITS-1:0]      drop_rate = '0;
	logic [COUNT_BITS-1:0]     drop_count = '0;
	logic                      out_ready = 1'b1;
	logic                      cfg_valid = 1'b0;
	logic [CFG_IDX_BITS-1:0]   cfg_index = REG_RATE_THRESHOLD;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
	logic                      in_ready;
	logic                      out_valid;
	logic [1:0]                alarm_state;
	logic                      alarm_or_hold;
	logic [2:0]                transition;
	logic [RATE_BITS-1:0]      display_rate;
	logic                      cfg_ready;

	int unsigned               fail_count;
	int unsigned               pending;
	int unsigned               cycles = 0;
	int unsigned               tick_total = 0;
	int                        gap_pct = 0;
	int                        stall_pct = 0;
	bit                        hold_off_req = 1'b0;
	logic [RATE_BITS-1:0]      cur_thr = RST_RATE_THRESHOLD;
	int                        pct_table [3] = '{0, 6, 30};

	drip_stop_alarm_supervisor_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .drop_rate(drop_rate), .drop_count(drop_count),
		.out_valid(out_valid), .out_ready(out_ready),
		.alarm_state(alarm_state), .alarm_or_hold(alarm_or_hold),
		.transition(transition), .display_rate(display_rate),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	dssup_alarm_checker watch (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .drop_rate(drop_rate), .drop_count(drop_count),
		.out_valid(out_valid), .out_ready(out_ready),
		.alarm_state(alarm_state), .alarm_or_hold(alarm_or_hold),
		.transition(transition), .display_rate(display_rate),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial forever #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("drip_stop_alarm_supervisor_core_tb: done, errors");
			$finish;
		end
	end

	initial forever begin
		@(negedge clk);
		if (hold_off_req) begin
			out_ready <= 1'b0;
			repeat (400) @(negedge clk);
			hold_off_req = 1'b0;
			out_ready <= 1'b1;
		end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
			out_ready <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
			out_ready <= 1'b1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic push_item(input logic m, input logic [RATE_BITS-1:0] r,
		input logic [COUNT_BITS-1:0] c);
		if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		drop_rate <= r;
		drop_count <= c;
		do @(posedge clk); while (!in_ready);
		if (m == MODE_TICK)
			tick_total++;
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (3) @(negedge clk);
	endtask

	task automatic program_limits(input logic [RATE_BITS-1:0] thr, input logic [COUNT_BITS-1:0] warm,
		input logic [COUNT_BITS-1:0] hold, input logic [COUNT_BITS-1:0] rec);
		logic [CFG_DATA_BITS-1:0] vals [4];
		logic [CFG_IDX_BITS-1:0]  regs [4];
		settle();
		vals = '{CFG_DATA_BITS'(thr), warm, hold, rec};
		regs = '{REG_RATE_THRESHOLD, REG_WARMUP_TICKS, REG_HOLD_TICKS, REG_RECOVERY_TICKS};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
		cur_thr = thr;
	endtask

	function automatic logic [COUNT_BITS-1:0] pick_span();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return COUNT_BITS'($urandom_range(0, 65535));
			default: return COUNT_BITS'($urandom_range(1, 10));
		endcase
	endfunction

	function automatic logic [RATE_BITS-1:0] rate_near(input bit good_side);
		int unsigned lo;
		int unsigned hi;
		if (good_side || cur_thr == 0) begin
			lo = 32'(cur_thr);
			hi = ($urandom_range(0, 3) == 0 || cur_thr > 4080) ? 4095 : 32'(cur_thr) + 15;
		end else begin
			hi = 32'(cur_thr) - 1;
			lo = ($urandom_range(0, 3) == 0 || cur_thr <= 16) ? 0 : 32'(cur_thr) - 16;
		end
		return RATE_BITS'($urandom_range(lo, hi));
	endfunction

	task automatic reshuffle_limits();
		logic [RATE_BITS-1:0]  thr;
		logic [COUNT_BITS-1:0] warm;
		case ($urandom_range(0, 5))
			0: thr = '0;
			1: thr = '1;
			2: thr = RATE_BITS'($urandom_range(0, 4095));
			default: thr = RATE_BITS'($urandom_range(1, 200));
		endcase
		case ($urandom_range(0, 5))
			0: warm = '0;
			1: warm = '1;
			2: warm = COUNT_BITS'(tick_total + $urandom_range(0, 40));
			3: warm = COUNT_BITS'($urandom_range(0, 65535));
			default: warm = COUNT_BITS'($urandom_range(0, 20));
		endcase
		program_limits(thr, warm, pick_span(), pick_span());
	endtask

	task automatic run_mix(input int n);
		int                    done_n;
		int                    pick;
		int                    len;
		bit                    good_side;
		logic [COUNT_BITS-1:0] cnt;
		done_n = 0;
		while (done_n < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				push_item(MODE_HOLD, RATE_BITS'($urandom_range(0, 4095)), COUNT_BITS'($urandom));
				done_n++;
			end else if (pick < 16) begin
				cnt = (pick < 12) ? '0 : COUNT_BITS'($urandom);
				push_item(MODE_TICK, RATE_BITS'($urandom_range(0, 4095)), cnt);
				done_n++;
			end else begin
				len = $urandom_range(1, 12);
				good_side = $urandom_range(0, 1);
				repeat (len) begin
					cnt = ($urandom_range(0, 19) == 0) ? '0 : COUNT_BITS'($urandom_range(1, 65535));
					push_item(MODE_TICK, rate_near(good_side), cnt);
					done_n++;
				end
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_item(MODE_TICK, 12'd0, 16'd1);
		push_item(MODE_TICK, 12'd4095, 16'hFFFF);
		push_item(MODE_HOLD, 12'd4095, 16'd0);
		push_item(MODE_HOLD, 12'd0, 16'hFFFF);
		push_item(MODE_TICK, 12'd9, 16'd0);

		program_limits(12'd4095, 16'd3, 16'd2, 16'd0);
		push_item(MODE_TICK, 12'd4094, 16'd0);
		push_item(MODE_TICK, 12'd0, 16'd1);
		push_item(MODE_HOLD, 12'd0, 16'd1);
		push_item(MODE_TICK, 12'd4095, 16'd5);
		push_item(MODE_TICK, 12'd0, 16'hFFFF);

		program_limits(12'd0, 16'hFFFF, 16'd0, 16'd2);
		push_item(MODE_TICK, 12'd0, 16'd1);
		push_item(MODE_TICK, 12'd0, 16'd1);
		push_item(MODE_TICK, 12'd0, 16'd1);
		push_item(MODE_HOLD, 12'd0, 16'd0);
		push_item(MODE_TICK, 12'd4095, 16'd1);

		program_limits(12'd100, 16'd0, 16'hFFFF, 16'd2);
		push_item(MODE_TICK, 12'd99, 16'd1);
		push_item(MODE_TICK, 12'd100, 16'd1);
		push_item(MODE_TICK, 12'd100, 16'd1);
		push_item(MODE_TICK, 12'd50, 16'd1);
		push_item(MODE_TICK, 12'd200, 16'd1);
		push_item(MODE_TICK, 12'd4095, 16'd1);
		push_item(MODE_TICK, 12'd200, 16'd1);
		push_item(MODE_HOLD, 12'd200, 16'd1);
		push_item(MODE_TICK, 12'd0, 16'd1);
		push_item(MODE_TICK, 12'd0, 16'd0);

		for (int seg = 0; seg < 16; seg++) begin
			reshuffle_limits();
			gap_pct = pct_table[$urandom_range(0, 2)];
			stall_pct = pct_table[$urandom_range(0, 2)];
			if (seg == 4)
				hold_off_req = 1'b1;
			run_mix($urandom_range(80, 120));
		end

		gap_pct = 0;
		stall_pct = 0;
		reshuffle_limits();
		run_mix(150);

		settle();
		repeat (7) @(negedge clk);
		if (fail_count == 0)
			$display("drip_stop_alarm_supervisor_core_tb: done, clean");
		else
			$display("drip_stop_alarm_supervisor_core_tb: done, errors");
		$finish;
	end

endmodule

// ===== files.f =====
src/dssup_pkg.sv
src/dssup_cfg_regs.sv
src/dssup_fsm.sv
src/drip_stop_alarm_supervisor_core.sv
bench/dssup_alarm_checker.sv
bench/drip_stop_alarm_supervisor_core_tb.sv
